// File: hw/rtl/bmp24_pkg.sv
`timescale 1ns / 1ps
package bmp24_pkg;

  typedef struct packed {
    logic [7:0] file_byte;
    logic       end_of_file;
  } in_item_t;

  typedef struct packed {
    logic [23:0] pixel_value;
    logic [25:0] pixel_address;
    logic        is_error;
    logic        last_pixel;
  } out_item_t;

  typedef enum logic [2:0] {
    PH_HEADER = 3'd0,
    PH_SKIP   = 3'd1,
    PH_PIXEL  = 3'd2,
    PH_PAD    = 3'd3,
    PH_DONE   = 3'd4,
    PH_ERROR  = 3'd5
  } phase_t;

  // Work handed from the parser to the pixel formatter.
  typedef struct packed {
    logic        is_error;
    logic        last_pixel;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [25:0] row_start;
    logic [12:0] column;
  } job_t;

  localparam logic [1:0] MODE_RGB565 = 2'd0;
  localparam logic [1:0] MODE_PACKED = 2'd1;
  localparam logic [5:0] HEADER_LEN  = 6'd54;
  localparam int unsigned QUEUE_DEPTH = 2;

  // Bytes per destination pixel for a mode; mode 3 acts as mode 2.
  function automatic logic [2:0] bytes_per_pixel(input logic [1:0] mode);
    unique case (mode)
      MODE_RGB565: bytes_per_pixel = 3'd2;
      MODE_PACKED: bytes_per_pixel = 3'd3;
      default:     bytes_per_pixel = 3'd4;
    endcase
  endfunction

endpackage

// File: hw/rtl/bmp24_parser.sv
`timescale 1ns / 1ps
module bmp24_parser #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                clk,
  input  logic                rst,
  input  logic [1:0]          dst_mode,
  input  logic                in_valid,
  input  bmp24_pkg::in_item_t in_data,
  output logic                in_stall,
  output logic                job_valid,
  output bmp24_pkg::job_t     job,
  input  logic                job_full
);
  import bmp24_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] byte_position;
  logic [31:0] data_offset;
  logic [31:0] raw_width, raw_height;
  logic [12:0] image_width, image_height;
  logic [15:0] bit_depth;
  logic [12:0] column_count, row_count;
  logic [1:0]  byte_in_pixel;
  logic [15:0] held_blue_green;
  logic [1:0]  pad_remaining;
  logic [25:0] row_start_address;

  // Row start multiply is split over two stages: row*width, then *bpp.
  logic        row_pending;
  logic        mult_stage;
  logic [25:0] row_product;

  logic        accept;
  logic [7:0]  b;
  logic [31:0] shifted;
  logic        header_bad;
  logic [12:0] dest_row;

  assign b        = in_data.file_byte;
  assign in_stall = job_full || row_pending;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    shifted = 32'(b) << {byte_position[1:0], 3'b000};
    header_bad = (bit_depth != 16'd24) || (raw_width == 32'd0) ||
                 (raw_width > 32'(MAX_WIDTH)) || (raw_height == 32'd0) ||
                 (raw_height > 32'(MAX_HEIGHT)) || (data_offset < 32'(HEADER_LEN));
    dest_row = image_height - 13'd1 - row_count;
  end

  always_comb begin
    phase_next = phase;
    job_valid  = 1'b0;
    job        = '0;
    job.red    = b;
    job.green  = held_blue_green[15:8];
    job.blue   = held_blue_green[7:0];
    job.row_start = row_start_address;
    job.column = column_count;
    if (accept) begin
      unique case (phase)
        PH_HEADER: begin
          if (byte_position == 32'(HEADER_LEN - 6'd1)) begin
            if (header_bad) begin
              phase_next = PH_ERROR;
              job_valid  = 1'b1;
              job        = '0;
              job.is_error = 1'b1;
            end else if (data_offset == 32'(HEADER_LEN)) begin
              phase_next = PH_PIXEL;
            end else begin
              phase_next = PH_SKIP;
            end
          end
        end
        PH_SKIP: begin
          if (byte_position + 32'd1 == data_offset) phase_next = PH_PIXEL;
        end
        PH_PIXEL: begin
          if (byte_in_pixel == 2'd2) begin
            job_valid = 1'b1;
            if (column_count + 13'd1 >= image_width) begin
              if (row_count + 13'd1 >= image_height) begin
                job.last_pixel = 1'b1;
                phase_next = PH_DONE;
              end else if (image_width[1:0] != 2'd0) begin
                phase_next = PH_PAD;
              end
            end
          end
        end
        PH_PAD: begin
          if (pad_remaining == 2'd1) phase_next = PH_PIXEL;
        end
        default: phase_next = phase;
      endcase
      if (in_data.end_of_file) phase_next = PH_HEADER;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HEADER;
      byte_position <= '0;
      data_offset <= '0;
      raw_width <= '0;
      raw_height <= '0;
      image_width <= '0;
      image_height <= '0;
      bit_depth <= '0;
      column_count <= '0;
      row_count <= '0;
      byte_in_pixel <= '0;
      held_blue_green <= '0;
      pad_remaining <= '0;
      row_start_address <= '0;
      row_pending <= 1'b0;
      mult_stage <= 1'b0;
      row_product <= '0;
    end else begin
      if (row_pending) begin
        if (!mult_stage) begin
          row_product <= 26'(dest_row * image_width);
          mult_stage  <= 1'b1;
        end else begin
          row_start_address <= 26'(row_product * bytes_per_pixel(dst_mode));
          mult_stage  <= 1'b0;
          row_pending <= 1'b0;
        end
      end
      if (accept) begin
        phase <= phase_next;
        unique case (phase)
          PH_HEADER: begin
            byte_position <= byte_position + 32'd1;
            if (byte_position >= 32'd10 && byte_position <= 32'd13)
              data_offset <= data_offset | (shifted << 16) | (shifted >> 16);
            else if (byte_position >= 32'd18 && byte_position <= 32'd21)
              raw_width <= raw_width | (shifted << 16) | (shifted >> 16);
            else if (byte_position >= 32'd22 && byte_position <= 32'd25)
              raw_height <= raw_height | (shifted << 16) | (shifted >> 16);
            else if (byte_position == 32'd28)
              bit_depth[7:0] <= b;
            else if (byte_position == 32'd29)
              bit_depth[15:8] <= b;
            if (byte_position == 32'(HEADER_LEN - 6'd1) && !header_bad) begin
              image_width  <= raw_width[12:0];
              image_height <= raw_height[12:0];
              row_count    <= '0;
              column_count <= '0;
              byte_in_pixel <= '0;
              row_pending  <= 1'b1;
            end
          end
          PH_SKIP: byte_position <= byte_position + 32'd1;
          PH_PIXEL: begin
            if (byte_in_pixel == 2'd0) begin
              held_blue_green <= {8'd0, b};
              byte_in_pixel <= 2'd1;
            end else if (byte_in_pixel == 2'd1) begin
              held_blue_green[15:8] <= b;
              byte_in_pixel <= 2'd2;
            end else begin
              byte_in_pixel <= 2'd0;
              column_count <= column_count + 13'd1;
              if (column_count + 13'd1 >= image_width) begin
                row_count <= row_count + 13'd1;
                if (row_count + 13'd1 < image_height) begin
                  if (image_width[1:0] != 2'd0) begin
                    pad_remaining <= image_width[1:0];
                  end else begin
                    column_count <= '0;
                    row_pending  <= 1'b1;
                  end
                end
              end
            end
          end
          PH_PAD: begin
            pad_remaining <= pad_remaining - 2'd1;
            if (pad_remaining == 2'd1) begin
              column_count <= '0;
              byte_in_pixel <= '0;
              row_pending <= 1'b1;
            end
          end
          default: ;
        endcase
        if (in_data.end_of_file) begin
          byte_position <= '0;
          data_offset <= '0;
          raw_width <= '0;
          raw_height <= '0;
          image_width <= '0;
          image_height <= '0;
          bit_depth <= '0;
          column_count <= '0;
          row_count <= '0;
          byte_in_pixel <= '0;
          held_blue_green <= '0;
          pad_remaining <= '0;
          row_start_address <= '0;
          row_pending <= 1'b0;
          mult_stage <= 1'b0;
        end
      end
    end
  end

  // The input is held off while the row start address is computed.
  assert property (@(posedge clk) disable iff (rst) row_pending |-> in_stall)
    else $error("byte taken during row address computation");
  assert property (@(posedge clk) disable iff (rst)
    job_valid |-> accept)
    else $error("job issued without an accepted beat");
  assert property (@(posedge clk) disable iff (rst)
    (job_valid && job.is_error) |-> !job.last_pixel)
    else $error("error job flagged as last pixel");
endmodule

// File: hw/rtl/bmp24_queue.sv
`timescale 1ns / 1ps
module bmp24_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bmp24_pkg::job_t push_data,
  output logic            full,
  output logic            pop_valid,
  output bmp24_pkg::job_t pop_data,
  input  logic            pop
);
  import bmp24_pkg::*;

  job_t       entries [QUEUE_DEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  assign full      = (count == 2'(QUEUE_DEPTH));
  assign pop_valid = (count != 2'd0);
  assign pop_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("queue overflow");
  assert property (@(posedge clk) disable iff (rst) !(pop && !pop_valid))
    else $error("queue underflow");
  assert property (@(posedge clk) disable iff (rst) count <= 2'(QUEUE_DEPTH))
    else $error("queue count out of range");
endmodule

// File: hw/rtl/bmp24_formatter.sv
`timescale 1ns / 1ps
module bmp24_formatter (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [1:0]           dst_mode,
  input  logic                 job_valid,
  input  bmp24_pkg::job_t      job,
  output logic                 job_pop,
  output logic                 out_valid,
  output bmp24_pkg::out_item_t out_data,
  input  logic                 out_stall
);
  import bmp24_pkg::*;

  out_item_t   result;
  logic [15:0] column_offset;
  logic        load;

  assign load    = job_valid && (!out_valid || !out_stall);
  assign job_pop = load;

  always_comb begin
    column_offset = 16'(job.column * bytes_per_pixel(dst_mode));
    result = '0;
    if (!job.is_error) begin
      if (dst_mode == MODE_RGB565)
        result.pixel_value = {8'd0, job.red[7:3], job.green[7:2], job.blue[7:3]};
      else
        result.pixel_value = {job.red, job.green, job.blue};
      result.pixel_address = job.row_start + 26'(column_offset);
      result.last_pixel = job.last_pixel;
    end
    result.is_error = job.is_error;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) out_data <= result;
  end

  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.is_error) |-> (out_data.pixel_value == 24'd0))
    else $error("error result carries pixel data");
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(out_data))
    else $error("stalled result changed");
endmodule

// File: hw/rtl/bmp24_stream_to_framebuffer.sv
`timescale 1ns / 1ps
// A pixel's red byte is pushed into the queue on the edge that accepts it; the
// formatter then registers it from the queue, and out_valid rises with that register.
// Throughput: one byte per cycle; the parser pauses at each row start
// while the row address multiply (row times width, then times bpp) runs,
// and holds input off while the two-entry queue is full under output stalls.
// Reset (rst, synchronous): parser returns to header parsing, queue empties,
// dst_mode returns to RGB565.
module bmp24_stream_to_framebuffer #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_HEIGHT = 4096
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  input  bmp24_pkg::in_item_t  in_data,
  output logic                 in_stall,
  output logic                 out_valid,
  output bmp24_pkg::out_item_t out_data,
  input  logic                 out_stall,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [1:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import bmp24_pkg::*;

  logic [1:0] dst_mode;
  logic       q_push, q_full, q_valid, q_pop;
  job_t       q_in, q_out;

  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {30'd0, dst_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) dst_mode <= MODE_RGB565;
    else if (psel && penable && pwrite && paddr == 2'd0) dst_mode <= pwdata[1:0];
  end

  bmp24_parser #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_parser (
    .clk, .rst, .dst_mode, .in_valid, .in_data, .in_stall,
    .job_valid(q_push), .job(q_in), .job_full(q_full)
  );

  bmp24_queue u_queue (
    .clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .pop_valid(q_valid), .pop_data(q_out), .pop(q_pop)
  );

  bmp24_formatter u_formatter (
    .clk, .rst, .dst_mode, .job_valid(q_valid), .job(q_out), .job_pop(q_pop),
    .out_valid, .out_data, .out_stall
  );
endmodule
